// File: rtl/core/bslru_pkg.sv
// Shared types, sizes and helpers for the book stack move-to-front hit counter.
// No dependencies; every other file in rtl/core imports this package.
package bslru_pkg;

    localparam int STACK_DEPTH = 256;
    localparam int WORD_BITS   = 32;

    // Cell index and in-use count widths follow from the stack depth.
    localparam int IDX_W     = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int USED_W    = $clog2(STACK_DEPTH + 1);
    localparam int PFX_LVLS  = $clog2(STACK_DEPTH);

    localparam int CNT_W = 48;
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    localparam int CFG_W       = 9;
    localparam int CFG_RESET   = 16;
    localparam int APB_DATA_W  = 32;
    localparam int APB_ADDR_W  = 3;
    localparam int REG_IDX_W   = 1;
    localparam logic [REG_IDX_W-1:0] REG_UPPER_SIZE = 1'b0;

    localparam logic ACT_PROCESS = 1'b0;
    localparam logic ACT_CLEAR   = 1'b1;

    typedef enum logic {
        ST_IDLE,
        ST_UPDATE
    } state_t;

    // Control broadcast from the sequencer to every cell of the chain.
    typedef struct packed {
        logic capture;  // register the compare result for the incoming word
        logic apply;    // commit the move-to-front update
        logic clear;    // refill the cell with its own index
    } cell_ctrl_t;

    // Refill value of a stack position: its index cut to the word width.
    function automatic logic [WORD_BITS-1:0] idx_word(input logic [IDX_W-1:0] idx);
        logic [WORD_BITS+IDX_W-1:0] wide;
        wide = {{WORD_BITS{1'b0}}, idx};
        return wide[WORD_BITS-1:0];
    endfunction

endpackage

// File: rtl/core/bslru_cell.sv
// One stack position of the move-to-front chain: holds a word and a match flag.
// Depends on bslru_pkg for widths, the control struct and the refill helper.
module bslru_cell (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [bslru_pkg::IDX_W-1:0]       cell_idx,
    input  logic [bslru_pkg::USED_W-1:0]      used,
    input  bslru_pkg::cell_ctrl_t             ctrl,
    input  logic [bslru_pkg::WORD_BITS-1:0]   cmp_word,
    input  logic [bslru_pkg::WORD_BITS-1:0]   prev_entry,
    input  logic                              seen_above,
    output logic [bslru_pkg::WORD_BITS-1:0]   entry,
    output logic                              match
);
    import bslru_pkg::*;

    logic [WORD_BITS-1:0] entry_reg;
    logic [WORD_BITS-1:0] entry_next;
    logic                 match_reg;
    logic                 match_next;
    logic                 in_use;

    assign in_use = (USED_W'(cell_idx) < used);

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.apply && ctrl.clear)
        begin
            entry_next = idx_word(cell_idx);
        end
        else if (ctrl.apply && in_use && !seen_above)
        begin
            // No match above this position: take the neighbor's word.
            entry_next = prev_entry;
        end
    end

    assign match_next = ctrl.capture ? (in_use && (entry_reg == cmp_word)) : match_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_reg <= idx_word(cell_idx);
        end
        else
        begin
            entry_reg <= entry_next;
        end
    end

    always_ff @(posedge clk)
    begin
        match_reg <= match_next;
    end

    assign entry = entry_reg;
    assign match = match_reg;

endmodule

// File: rtl/core/bslru_prefix.sv
// Log-depth prefix OR over the registered match flags of the cell chain.
// Depends on bslru_pkg for the stack depth and the number of levels.
module bslru_prefix (
    input  logic [bslru_pkg::STACK_DEPTH-1:0] match_vec,
    output logic [bslru_pkg::STACK_DEPTH-1:0] above_vec,
    output logic                              any_match
);
    import bslru_pkg::*;

    logic [STACK_DEPTH-1:0] lvl [0:PFX_LVLS];

    // Each level widens the OR span by a power of two.
    always_comb
    begin
        lvl[0] = match_vec;
        for (int l = 0; l < PFX_LVLS; l++)
        begin
            for (int k = 0; k < STACK_DEPTH; k++)
            begin
                if (k >= (1 << l))
                begin
                    lvl[l+1][k] = lvl[l][k] | lvl[l][k - (1 << l)];
                end
                else
                begin
                    lvl[l+1][k] = lvl[l][k];
                end
            end
        end
    end

    // Position k sees a match strictly above it when any of 0..k-1 matched.
    always_comb
    begin
        above_vec[0] = 1'b0;
        for (int k = 1; k < STACK_DEPTH; k++)
        begin
            above_vec[k] = lvl[PFX_LVLS][k-1];
        end
    end

    assign any_match = lvl[PFX_LVLS][STACK_DEPTH-1];

endmodule

// File: rtl/core/book_stack_lru_hit_counter_unit.sv
// A word is accepted only in idle, so a new word is not taken before the last one is
// through; the compare cycle fills the match flags of the cell chain and the update
// cycle resolves the topmost match, shifts the chain and registers the result word.
// The update cycle is held off while the output register still holds a word not yet taken.
// Reset: stack position i holds i, both counters are zero, upper_size is 16.
// Depends on bslru_pkg, bslru_cell and bslru_prefix.
module book_stack_lru_hit_counter_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    // Configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [bslru_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [bslru_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [bslru_pkg::APB_DATA_W-1:0]    prdata,
    output logic                                pready,
    // Input channel
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                action,
    input  logic [31:0]                         word_value,
    // Output channel
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                hit,
    output logic [bslru_pkg::CNT_W-1:0]         upper_hits,
    output logic [bslru_pkg::CNT_W-1:0]         lower_misses
);
    import bslru_pkg::*;

    // ------------------------------------------------------------------
    // Configuration register. Writes land on the access phase; only the
    // register at index zero exists, anything else reads as zero.
    // ------------------------------------------------------------------
    logic [CFG_W-1:0]     upper_size_reg;
    logic [CFG_W-1:0]     upper_size_next;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 cfg_write;

    assign pready    = 1'b1;
    assign reg_idx   = paddr[APB_ADDR_W-1:2];
    assign cfg_write = psel && penable && pwrite;

    always_comb
    begin
        upper_size_next = upper_size_reg;
        if (cfg_write && (reg_idx == REG_UPPER_SIZE))
        begin
            upper_size_next = pwdata[CFG_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (reg_idx == REG_UPPER_SIZE)
        begin
            prdata = APB_DATA_W'(upper_size_reg);
        end
    end

    // Number of positions in use: zero behaves as one, and anything above
    // the physical depth is held at the depth.
    logic [USED_W-1:0] used;

    always_comb
    begin
        if (upper_size_reg == '0)
        begin
            used = USED_W'(1);
        end
        else if (int'(upper_size_reg) > STACK_DEPTH)
        begin
            used = USED_W'(STACK_DEPTH);
        end
        else
        begin
            used = USED_W'(upper_size_reg);
        end
    end

    // ------------------------------------------------------------------
    // Sequencer. In idle the block takes a word and every cell in use registers
    // whether it holds that word. In the update cycle the prefix OR picks the
    // topmost match, the chain shifts down to the hit position (or to the last
    // position in use on a miss), the word lands on top and the counters move;
    // a clear action instead refills each cell with its index and zeroes the
    // counters. The update waits only while the output register holds a word not yet taken.
    // ------------------------------------------------------------------
    state_t               state_reg;
    state_t               state_next;
    logic                 action_reg;
    logic                 action_next;
    logic [WORD_BITS-1:0] word_reg;
    logic [WORD_BITS-1:0] word_next;
    cell_ctrl_t           ctrl;
    logic                 in_fire;
    logic                 out_free;

    assign in_fire  = in_valid && in_ready;
    assign out_free = !out_valid || out_ready;

    always_comb
    begin
        state_next   = state_reg;
        in_ready     = 1'b0;
        ctrl.capture = 1'b0;
        ctrl.apply   = 1'b0;
        ctrl.clear   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready     = 1'b1;
                ctrl.capture = in_valid;
                if (in_valid)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                if (out_free)
                begin
                    ctrl.apply = 1'b1;
                    ctrl.clear = (action_reg == ACT_CLEAR);
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign action_next = in_fire ? action : action_reg;
    assign word_next   = in_fire ? word_value[WORD_BITS-1:0] : word_reg;

    // ------------------------------------------------------------------
    // Cell chain. Cell 0 is the top of the stack and takes the incoming
    // word; every other cell takes its upper neighbor's word when it is in
    // use and no position above it matched.
    // ------------------------------------------------------------------
    logic [WORD_BITS-1:0]   entry_w [STACK_DEPTH];
    logic [STACK_DEPTH-1:0] match_vec;
    logic [STACK_DEPTH-1:0] above_vec;
    logic                   any_match;

    for (genvar k = 0; k < STACK_DEPTH; k++)
    begin : g_cell
        logic [WORD_BITS-1:0] prev_w;
        if (k == 0)
        begin : g_top
            assign prev_w = word_reg;
        end
        else
        begin : g_below
            assign prev_w = entry_w[k-1];
        end

        bslru_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .cell_idx   (IDX_W'(k)),
            .used       (used),
            .ctrl       (ctrl),
            .cmp_word   (word_value[WORD_BITS-1:0]),
            .prev_entry (prev_w),
            .seen_above (above_vec[k]),
            .entry      (entry_w[k]),
            .match      (match_vec[k])
        );
    end

    bslru_prefix u_prefix (
        .match_vec (match_vec),
        .above_vec (above_vec),
        .any_match (any_match)
    );

    // ------------------------------------------------------------------
    // Saturating counters and the output register.
    // ------------------------------------------------------------------
    logic [CNT_W-1:0] hit_cnt_reg;
    logic [CNT_W-1:0] hit_cnt_next;
    logic [CNT_W-1:0] miss_cnt_reg;
    logic [CNT_W-1:0] miss_cnt_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             hit_reg;
    logic             hit_next;
    logic [CNT_W-1:0] upper_hits_reg;
    logic [CNT_W-1:0] upper_hits_next;
    logic [CNT_W-1:0] lower_misses_reg;
    logic [CNT_W-1:0] lower_misses_next;

    always_comb
    begin
        hit_cnt_next  = hit_cnt_reg;
        miss_cnt_next = miss_cnt_reg;
        hit_next      = hit_reg;
        if (ctrl.apply)
        begin
            hit_next = 1'b0;
            if (ctrl.clear)
            begin
                hit_cnt_next  = '0;
                miss_cnt_next = '0;
            end
            else if (any_match)
            begin
                hit_next = 1'b1;
                if (hit_cnt_reg != CNT_MAX)
                begin
                    hit_cnt_next = hit_cnt_reg + CNT_W'(1);
                end
            end
            else if (miss_cnt_reg != CNT_MAX)
            begin
                miss_cnt_next = miss_cnt_reg + CNT_W'(1);
            end
        end
    end

    always_comb
    begin
        out_valid_next    = out_valid_reg && !out_ready;
        upper_hits_next   = upper_hits_reg;
        lower_misses_next = lower_misses_reg;
        if (ctrl.apply)
        begin
            out_valid_next    = 1'b1;
            upper_hits_next   = hit_cnt_next;
            lower_misses_next = miss_cnt_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            upper_size_reg <= CFG_W'(CFG_RESET);
            hit_cnt_reg    <= '0;
            miss_cnt_reg   <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            upper_size_reg <= upper_size_next;
            hit_cnt_reg    <= hit_cnt_next;
            miss_cnt_reg   <= miss_cnt_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        action_reg       <= action_next;
        word_reg         <= word_next;
        hit_reg          <= hit_next;
        upper_hits_reg   <= upper_hits_next;
        lower_misses_reg <= lower_misses_next;
    end

    assign out_valid    = out_valid_reg;
    assign hit          = hit_reg;
    assign upper_hits   = upper_hits_reg;
    assign lower_misses = lower_misses_reg;

endmodule
